// ----- src/mtep_pkg.sv -----
// Package for the MIDI track event parser: parse phases, status and meta codes,
// event kinds and the result record type.
// No dependencies.
package mtep_pkg;

  // Parse phase of the byte stream
  typedef enum logic [2:0] {
    PH_DELTA     = 3'd0,
    PH_STATUS    = 3'd1,
    PH_CH_DATA   = 3'd2,
    PH_SYSEX_LEN = 3'd3,
    PH_META_TYPE = 3'd4,
    PH_META_LEN  = 3'd5,
    PH_META_DATA = 3'd6,
    PH_SKIP      = 3'd7
  } phase_t;

  // Status and meta type codes
  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_TSIG  = 8'h58;

  // Channel message high nibbles
  localparam logic [3:0] CH_NOTE_OFF  = 4'h8;
  localparam logic [3:0] CH_NOTE_ON   = 4'h9;
  localparam logic [3:0] CH_POLY_PRES = 4'hA;
  localparam logic [3:0] CH_PROGRAM   = 4'hC;
  localparam logic [3:0] CH_CHAN_PRES = 4'hD;
  localparam logic [3:0] CH_LAST      = 4'hE;

  // Event kinds
  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_TEMPO    = 3'd2;
  localparam logic [2:0] KIND_TSIG     = 3'd3;
  localparam logic [2:0] KIND_OTHER    = 3'd4;
  localparam logic [2:0] KIND_ERROR    = 3'd5;

  // Output data word width (108 field bits padded to whole bytes)
  localparam int unsigned EV_DATA_W = 112;

  // One decoded event
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] delta_time;
    logic [3:0]  channel;
    logic [7:0]  note_number;
    logic [7:0]  velocity;
    logic [23:0] tempo_value;
    logic [7:0]  sig_numerator;
    logic [7:0]  sig_denominator;
    logic [7:0]  sig_clocks;
    logic [7:0]  sig_thirtyseconds;
  } event_t;

endpackage

// ----- src/midi_track_event_parser_core.sv -----
// MIDI track event parser top level: byte-wide input stream, decoded event stream.
// Depends on mtep_pkg.
//
// Usage:
//   Input stream (s_axis_*): one track-body byte per transfer in tdata; tuser
//   bit 0 marks the first byte of a new track and clears running status and the
//   parse phase before that byte is used.
//   Output stream (m_axis_*): one transfer per decoded event. tuser carries the
//   event kind, tdata the event fields (see port comments). Sysex events, delta
//   bytes and skipped payload bytes give no output; a length byte gives one only
//   when it ends the length of a meta event other than tempo or time signature.
//   An event is registered when the byte that completes it is transferred in.
//   Throughput: one byte per cycle while tready is high; the parse state is
//   updated in one pass of combinational logic between the state registers
//   and the result register. Stall: results sit in an output register backed
//   by one skid register, so input keeps flowing while one result waits;
//   input tready drops only when both hold an event.
//   Reset: rst (synchronous, active high) puts the parser at the start of a
//   delta time with no running status and empties the output registers.
module midi_track_event_parser_core
  import mtep_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] track_byte
  input  logic [0:0]           s_axis_tuser,  // [0] track_begin
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] delta_time, [35:32] channel, [43:36] note_number, [51:44] velocity,
  // [75:52] tempo_value, [83:76] sig_numerator, [91:84] sig_denominator,
  // [99:92] sig_clocks, [107:100] sig_thirtyseconds, [111:108] zero
  output logic [EV_DATA_W-1:0] m_axis_tdata,
  output logic [2:0]           m_axis_tuser   // [2:0] event_kind
);

  // Parse state
  phase_t      phase, phase_next;
  logic [31:0] delta_accum, delta_accum_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] bytes_to_skip, bytes_to_skip_next;
  logic [7:0]  running_stat, running_stat_next;
  logic [7:0]  current_stat, current_stat_next;
  logic [7:0]  meta_kind, meta_kind_next;
  logic [7:0]  payload_bytes [4];
  logic [7:0]  payload_bytes_next [4];
  logic [2:0]  payload_count, payload_count_next;

  // Result of the current byte
  logic        res_valid;
  event_t      res;

  // Output and skid registers
  logic        out_valid, skid_valid;
  event_t      out_ev, skid_ev;

  logic [7:0]  b;
  logic        in_xfer, push, pop;
  logic        need_one, need_three, meta_done;
  logic [31:0] meta_need;
  logic [3:0]  stat_hi;

  assign b       = s_axis_tdata;
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign push    = in_xfer && res_valid;
  assign pop     = out_valid && m_axis_tready;

  // Next parse state and result for one byte
  always_comb begin
    phase_next         = phase;
    delta_accum_next   = delta_accum;
    length_accum_next  = length_accum;
    bytes_to_skip_next = bytes_to_skip;
    running_stat_next  = running_stat;
    current_stat_next  = current_stat;
    meta_kind_next     = meta_kind;
    payload_bytes_next = payload_bytes;
    payload_count_next = payload_count;
    res_valid          = 1'b0;
    res                = '0;
    need_one           = 1'b0;
    need_three         = 1'b0;
    meta_done          = 1'b0;
    meta_need          = '0;
    stat_hi            = b[7:4];

    // New track: clear running status and restart at a delta time
    if (s_axis_tuser[0]) begin
      running_stat_next  = '0;
      current_stat_next  = '0;
      meta_kind_next     = '0;
      length_accum_next  = '0;
      bytes_to_skip_next = '0;
      payload_count_next = '0;
      phase_next         = PH_DELTA;
      delta_accum_next   = '0;
    end

    case (phase_next)
      PH_DELTA: begin
        delta_accum_next = {delta_accum_next[24:0], b[6:0]};
        if (!b[7]) begin
          phase_next = PH_STATUS;
        end
      end

      PH_STATUS: begin
        if (b == ST_SYSEX) begin
          length_accum_next = '0;
          phase_next        = PH_SYSEX_LEN;
        end else if (b == ST_META) begin
          phase_next = PH_META_TYPE;
        end else if (stat_hi >= CH_NOTE_OFF && stat_hi <= CH_LAST) begin
          running_stat_next  = b;
          current_stat_next  = b;
          payload_count_next = '0;
          phase_next         = PH_CH_DATA;
        end else if (running_stat_next == '0) begin
          // data byte with no running status
          res_valid        = 1'b1;
          res.event_kind   = KIND_ERROR;
          res.delta_time   = delta_accum_next;
          phase_next       = PH_DELTA;
          delta_accum_next = '0;
        end else begin
          current_stat_next     = running_stat_next;
          payload_bytes_next[0] = b;
          payload_count_next    = 3'd1;
          phase_next            = PH_CH_DATA;
        end
      end

      PH_CH_DATA: begin
        payload_bytes_next[payload_count_next[1:0]] = b;
        payload_count_next = payload_count_next + 3'd1;
      end

      PH_SYSEX_LEN: begin
        length_accum_next = {length_accum_next[24:0], b[6:0]};
        if (!b[7]) begin
          if (length_accum_next == '0) begin
            phase_next       = PH_DELTA;
            delta_accum_next = '0;
          end else begin
            bytes_to_skip_next = length_accum_next;
            phase_next         = PH_SKIP;
          end
        end
      end

      PH_META_TYPE: begin
        meta_kind_next    = b;
        length_accum_next = '0;
        phase_next        = PH_META_LEN;
      end

      PH_META_LEN: begin
        length_accum_next = {length_accum_next[24:0], b[6:0]};
        if (!b[7]) begin
          if (meta_kind_next == META_TEMPO || meta_kind_next == META_TSIG) begin
            payload_count_next = '0;
            phase_next         = PH_META_DATA;
          end else begin
            res_valid      = 1'b1;
            res.event_kind = KIND_OTHER;
            res.delta_time = delta_accum_next;
            if (length_accum_next == '0) begin
              phase_next       = PH_DELTA;
              delta_accum_next = '0;
            end else begin
              bytes_to_skip_next = length_accum_next;
              phase_next         = PH_SKIP;
            end
          end
        end
      end

      PH_META_DATA: begin
        payload_bytes_next[payload_count_next[1:0]] = b;
        payload_count_next = payload_count_next + 3'd1;
        need_three = (meta_kind_next == META_TEMPO);
        meta_need  = need_three ? 32'd3 : 32'd4;
        meta_done  = ({29'd0, payload_count_next} >= meta_need);
        if (meta_done) begin
          res_valid      = 1'b1;
          res.delta_time = delta_accum_next;
          if (need_three) begin
            res.event_kind  = KIND_TEMPO;
            res.tempo_value = {payload_bytes_next[0], payload_bytes_next[1],
                               payload_bytes_next[2]};
          end else begin
            res.event_kind        = KIND_TSIG;
            res.sig_numerator     = payload_bytes_next[0];
            res.sig_denominator   = payload_bytes_next[1];
            res.sig_clocks        = payload_bytes_next[2];
            res.sig_thirtyseconds = payload_bytes_next[3];
          end
          // skip whatever the declared length has beyond the fixed payload
          if (length_accum_next > meta_need) begin
            bytes_to_skip_next = length_accum_next - meta_need;
            phase_next         = PH_SKIP;
          end else begin
            phase_next       = PH_DELTA;
            delta_accum_next = '0;
          end
        end
      end

      PH_SKIP: begin
        if (bytes_to_skip_next != '0) begin
          bytes_to_skip_next = bytes_to_skip_next - 32'd1;
        end
        if (bytes_to_skip_next == '0) begin
          phase_next       = PH_DELTA;
          delta_accum_next = '0;
        end
      end

      default: begin
        phase_next       = PH_DELTA;
        delta_accum_next = '0;
      end
    endcase

    // Channel event completes once its data bytes are in
    if ((phase == PH_STATUS || phase == PH_CH_DATA || s_axis_tuser[0]) &&
        phase_next == PH_CH_DATA) begin
      need_one = (current_stat_next[7:4] == CH_PROGRAM) ||
                 (current_stat_next[7:4] == CH_CHAN_PRES);
      if (payload_count_next >= (need_one ? 3'd1 : 3'd2)) begin
        res_valid      = 1'b1;
        res.delta_time = delta_accum_next;
        if (current_stat_next[7:4] == CH_NOTE_OFF) begin
          res.event_kind = KIND_NOTE_OFF;
        end else if (current_stat_next[7:4] == CH_NOTE_ON ||
                     current_stat_next[7:4] == CH_POLY_PRES) begin
          res.event_kind = KIND_NOTE_ON;
        end else begin
          res.event_kind = KIND_OTHER;
        end
        if (res.event_kind != KIND_OTHER) begin
          res.channel     = current_stat_next[3:0];
          res.note_number = payload_bytes_next[0];
          res.velocity    = payload_bytes_next[1];
        end
        phase_next       = PH_DELTA;
        delta_accum_next = '0;
      end
    end
  end

  // Parse state registers, updated on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DELTA;
      delta_accum   <= '0;
      length_accum  <= '0;
      bytes_to_skip <= '0;
      running_stat  <= '0;
      current_stat  <= '0;
      meta_kind     <= '0;
      payload_count <= '0;
    end else if (in_xfer) begin
      phase         <= phase_next;
      delta_accum   <= delta_accum_next;
      length_accum  <= length_accum_next;
      bytes_to_skip <= bytes_to_skip_next;
      running_stat  <= running_stat_next;
      current_stat  <= current_stat_next;
      meta_kind     <= meta_kind_next;
      payload_count <= payload_count_next;
    end
  end

  // Payload byte store, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      payload_bytes <= payload_bytes_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_ev     <= skid_ev;
        skid_valid <= push;
        if (push) begin
          skid_ev <= res;
        end
      end else begin
        out_valid <= push;
        if (push) begin
          out_ev <= res;
        end
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_ev    <= res;
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_ev.event_kind;
  assign m_axis_tdata  = {4'd0,
                          out_ev.sig_thirtyseconds,
                          out_ev.sig_clocks,
                          out_ev.sig_denominator,
                          out_ev.sig_numerator,
                          out_ev.tempo_value,
                          out_ev.velocity,
                          out_ev.note_number,
                          out_ev.channel,
                          out_ev.delta_time};

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for midi_track_event_parser_core: directed track bytes, then random
// event streams, every result checked against a fixed event or a behavioral parser. Depends on mtep_pkg.
module testbench;
  import mtep_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1850;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;  // [7:0] track_byte
  logic [0:0]           s_axis_tuser = '0;  // [0] track_begin
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [31:0] delta_time, [35:32] channel, [43:36] note_number, [51:44] velocity,
  // [75:52] tempo_value, [83:76] sig_numerator, [91:84] sig_denominator,
  // [99:92] sig_clocks, [107:100] sig_thirtyseconds, [111:108] zero
  logic [EV_DATA_W-1:0] m_axis_tdata;
  logic [2:0]           m_axis_tuser;       // [2:0] event_kind

  midi_track_event_parser_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // Directed stimulus row; ev is used when fixed is set
  typedef struct {
    logic [7:0] b;
    bit         tb;
    bit         fixed;
    event_t     ev;
  } stim_row_t;

  stim_row_t   stim_rows[$];
  event_t      pending_events[$];
  int unsigned fail_cnt = 0;
  int unsigned byte_cnt = 0;
  int unsigned burst_left = 0;

  // Parser state mirror
  phase_t      ph_q        = PH_DELTA;
  logic [31:0] delta_acc   = '0;
  logic [31:0] len_acc     = '0;
  logic [31:0] skip_left   = '0;
  logic [7:0]  run_status  = '0;
  logic [7:0]  cur_status  = '0;
  logic [7:0]  meta_type   = '0;
  logic [7:0]  payload [4] = '{default: '0};
  logic [2:0]  payload_cnt = '0;

  // Random stream shaping
  logic [7:0]  gen_status = '0;
  bit          gen_fresh  = 1'b1;

  function automatic logic [31:0] vlq_add(logic [31:0] acc, logic [7:0] b);
    return {acc[24:0], 7'd0} + {25'd0, b[6:0]};
  endfunction

  // Data bytes per channel status: program and channel pressure take one
  function automatic int unsigned data_need(logic [7:0] st);
    return (st[7:4] == CH_PROGRAM || st[7:4] == CH_CHAN_PRES) ? 1 : 2;
  endfunction

  function automatic void back_to_delta();
    ph_q      = PH_DELTA;
    delta_acc = '0;
  endfunction

  function automatic void skip_payload(logic [31:0] n);
    if (n == 0) begin
      back_to_delta();
    end else begin
      skip_left = n;
      ph_q      = PH_SKIP;
    end
  endfunction

  function automatic event_t channel_done();
    event_t e;
    e = '0;
    e.delta_time = delta_acc;
    if (cur_status[7:4] == CH_NOTE_OFF) e.event_kind = KIND_NOTE_OFF;
    else if (cur_status[7:4] == CH_NOTE_ON || cur_status[7:4] == CH_POLY_PRES)
      e.event_kind = KIND_NOTE_ON;
    else e.event_kind = KIND_OTHER;
    if (e.event_kind != KIND_OTHER) begin
      e.channel     = cur_status[3:0];
      e.note_number = payload[0];
      e.velocity    = payload[1];
    end
    back_to_delta();
    return e;
  endfunction

  // Advance the parser mirror by one byte; returns 1 when an event completes
  function automatic bit decode_byte(input logic [7:0] b, input bit tb, output event_t ev);
    int unsigned need;
    bit          hit;
    ev  = '0;
    hit = 1'b0;
    if (tb) begin
      run_status  = '0;
      cur_status  = '0;
      meta_type   = '0;
      len_acc     = '0;
      skip_left   = '0;
      payload_cnt = '0;
      back_to_delta();
    end
    case (ph_q)
      PH_DELTA: begin
        delta_acc = vlq_add(delta_acc, b);
        if (!b[7]) ph_q = PH_STATUS;
      end
      PH_STATUS: begin
        if (b == ST_SYSEX) begin
          len_acc = '0;
          ph_q    = PH_SYSEX_LEN;
        end else if (b == ST_META) begin
          ph_q = PH_META_TYPE;
        end else if (b[7:4] >= CH_NOTE_OFF && b[7:4] <= CH_LAST) begin
          run_status  = b;
          cur_status  = b;
          payload_cnt = '0;
          ph_q        = PH_CH_DATA;
        end else if (run_status == 0) begin
          // data byte with no running status
          ev.event_kind = KIND_ERROR;
          ev.delta_time = delta_acc;
          back_to_delta();
          hit = 1'b1;
        end else begin
          cur_status  = run_status;
          payload[0]  = b;
          payload_cnt = 3'd1;
          if (data_need(cur_status) == 1) begin
            ev  = channel_done();
            hit = 1'b1;
          end else begin
            ph_q = PH_CH_DATA;
          end
        end
      end
      PH_CH_DATA: begin
        payload[payload_cnt[1:0]] = b;
        payload_cnt = payload_cnt + 3'd1;
        if (payload_cnt >= data_need(cur_status)) begin
          ev  = channel_done();
          hit = 1'b1;
        end
      end
      PH_SYSEX_LEN: begin
        len_acc = vlq_add(len_acc, b);
        if (!b[7]) skip_payload(len_acc);
      end
      PH_META_TYPE: begin
        meta_type = b;
        len_acc   = '0;
        ph_q      = PH_META_LEN;
      end
      PH_META_LEN: begin
        len_acc = vlq_add(len_acc, b);
        if (!b[7]) begin
          if (meta_type == META_TEMPO || meta_type == META_TSIG) begin
            payload_cnt = '0;
            ph_q        = PH_META_DATA;
          end else begin
            ev.event_kind = KIND_OTHER;
            ev.delta_time = delta_acc;
            skip_payload(len_acc);
            hit = 1'b1;
          end
        end
      end
      PH_META_DATA: begin
        payload[payload_cnt[1:0]] = b;
        payload_cnt = payload_cnt + 3'd1;
        need = (meta_type == META_TEMPO) ? 3 : 4;
        if (payload_cnt >= need) begin
          ev.delta_time = delta_acc;
          if (need == 3) begin
            ev.event_kind  = KIND_TEMPO;
            ev.tempo_value = {payload[0], payload[1], payload[2]};
          end else begin
            ev.event_kind        = KIND_TSIG;
            ev.sig_numerator     = payload[0];
            ev.sig_denominator   = payload[1];
            ev.sig_clocks        = payload[2];
            ev.sig_thirtyseconds = payload[3];
          end
          // longer payloads: skip what is left of the declared length
          skip_payload(len_acc > need ? len_acc - need : 32'd0);
          hit = 1'b1;
        end
      end
      default: begin
        if (skip_left > 0) skip_left = skip_left - 1;
        if (skip_left == 0) back_to_delta();
      end
    endcase
    return hit;
  endfunction

  function automatic event_t mk_event(logic [2:0] kind, logic [31:0] dt, logic [3:0] ch,
                                      logic [7:0] key, logic [7:0] vel, logic [23:0] tempo,
                                      logic [7:0] num, logic [7:0] den, logic [7:0] clks,
                                      logic [7:0] t32);
    event_t e;
    e.event_kind        = kind;
    e.delta_time        = dt;
    e.channel           = ch;
    e.note_number       = key;
    e.velocity          = vel;
    e.tempo_value       = tempo;
    e.sig_numerator     = num;
    e.sig_denominator   = den;
    e.sig_clocks        = clks;
    e.sig_thirtyseconds = t32;
    return e;
  endfunction

  function automatic void add_row(logic [7:0] b, bit tb);
    stim_rows.push_back('{b, tb, 1'b0, '0});
  endfunction

  function automatic void add_fixed(logic [7:0] b, event_t e);
    stim_rows.push_back('{b, 1'b0, 1'b1, e});
  endfunction

  // Send one byte, queue its expected event, and apply the burst/gap pattern
  task automatic send_byte(input logic [7:0] b, input bit tb, input bit fixed = 1'b0,
                           input event_t fixed_ev = '0);
    event_t pred;
    bit     hit;
    hit = decode_byte(b, tb, pred);
    if (fixed) pending_events.push_back(fixed_ev);
    else if (hit) pending_events.push_back(pred);
    byte_cnt++;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= tb;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(0, 15);
    end
  endtask

  // Mostly 0..127 data, sometimes with the high bit set
  function automatic logic [7:0] data_byte();
    return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 127))
                                        : 8'($urandom_range(128, 255));
  endfunction

  // Variable-length quantity under 128, optionally padded or wrapped past 32 bits
  task automatic send_length(input int unsigned n);
    int unsigned form;
    form = $urandom_range(0, 9);
    if (form == 0) begin
      send_byte(8'h90, 1'b0);
      repeat (3) send_byte(8'h80, 1'b0);
    end else if (form == 1) begin
      send_byte(8'h80, 1'b0);
    end
    send_byte(8'(n), 1'b0);
  endtask

  // One well-formed event with random content, or a short burst of noise
  task automatic gen_event();
    int unsigned pick, n, len, k;
    logic [7:0]  st, mt;
    bit          tb;
    if ($urandom_range(0, 99) < 4) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
      gen_fresh  = 1'b1;
      gen_status = '0;
    end else begin
      tb = gen_fresh || ($urandom_range(0, 99) < 3);
      if (tb) gen_status = '0;
      gen_fresh = 1'b0;
      // delta time
      pick = $urandom_range(0, 99);
      n = (pick < 60) ? 1 : (pick < 85) ? 2 : (pick < 95) ? 3 : $urandom_range(4, 5);
      for (k = 0; k < n; k++)
        send_byte({k < n - 1, 7'($urandom)}, tb && k == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        st = {4'($urandom_range(8, 14)), 4'($urandom)};
        gen_status = st;
        send_byte(st, 1'b0);
        repeat (data_need(st)) send_byte(data_byte(), 1'b0);
      end else if (pick < 60) begin
        // running status, sometimes led by a stray system byte
        send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(8'hF1, 8'hFE))
                                              : 8'($urandom_range(0, 127)), 1'b0);
        if (gen_status != 0 && data_need(gen_status) == 2) send_byte(data_byte(), 1'b0);
      end else if (pick < 70) begin
        send_byte(ST_SYSEX, 1'b0);
        len = $urandom_range(0, 8);
        send_length(len);
        repeat (len) send_byte(8'($urandom), 1'b0);
      end else begin
        send_byte(ST_META, 1'b0);
        pick = $urandom_range(0, 9);
        mt = (pick < 4) ? META_TEMPO : (pick < 8) ? META_TSIG : 8'($urandom);
        send_byte(mt, 1'b0);
        len = $urandom_range(0, 7);
        send_length(len);
        n = (mt == META_TEMPO) ? 3 : (mt == META_TSIG) ? 4 : 0;
        repeat ((len > n) ? len : n) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Result check and receiver stall pattern
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  always @(posedge clk) begin
    event_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_events.size() == 0) begin
          $error("event_kind: expected none, actual %0h", m_axis_tuser);
          fail_cnt++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_kind", 32'(want.event_kind), 32'(m_axis_tuser));
          check_field("delta_time", want.delta_time, m_axis_tdata[31:0]);
          check_field("channel", 32'(want.channel), 32'(m_axis_tdata[35:32]));
          check_field("note_number", 32'(want.note_number), 32'(m_axis_tdata[43:36]));
          check_field("velocity", 32'(want.velocity), 32'(m_axis_tdata[51:44]));
          check_field("tempo_value", 32'(want.tempo_value), 32'(m_axis_tdata[75:52]));
          check_field("sig_numerator", 32'(want.sig_numerator),
                      32'(m_axis_tdata[83:76]));
          check_field("sig_denominator", 32'(want.sig_denominator),
                      32'(m_axis_tdata[91:84]));
          check_field("sig_clocks", 32'(want.sig_clocks), 32'(m_axis_tdata[99:92]));
          check_field("sig_thirtyseconds", 32'(want.sig_thirtyseconds),
                      32'(m_axis_tdata[107:100]));
          check_field("padding", 32'd0, 32'(m_axis_tdata[111:108]));
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("midi_track_event_parser_core verification failed");
    $finish;
  end

  initial begin
    // data byte with no running status
    add_row(8'h05, 1'b1);
    add_fixed(8'h40, mk_event(KIND_ERROR, 32'd5, '0, '0, '0, '0, '0, '0, '0, '0));
    // five-byte delta that wraps to all ones, note off with high-bit data
    add_row(8'h8F, 1'b0);
    repeat (3) add_row(8'hFF, 1'b0);
    add_row(8'h7F, 1'b0);
    add_row(8'h8F, 1'b0);
    add_row(8'hFF, 1'b0);
    add_fixed(8'h00, mk_event(KIND_NOTE_OFF, 32'hFFFF_FFFF, 4'hF, 8'hFF, 8'h00,
                              '0, '0, '0, '0, '0));
    // stray system byte taken as data under running status
    add_row(8'h00, 1'b0);
    add_row(8'hF5, 1'b0);
    add_row(8'h11, 1'b0);
    // tempo with a declared length shorter than three
    add_row(8'h00, 1'b0);
    add_row(ST_META, 1'b0);
    add_row(META_TEMPO, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h07, 1'b0);
    add_row(8'hA1, 1'b0);
    add_fixed(8'h20, mk_event(KIND_TEMPO, 32'd0, '0, '0, '0, 24'h07A120,
                              '0, '0, '0, '0));
    // time signature
    add_row(8'h03, 1'b0);
    add_row(ST_META, 1'b0);
    add_row(META_TSIG, 1'b0);
    add_row(8'h04, 1'b0);
    add_row(8'h04, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h18, 1'b0);
    add_fixed(8'h08, mk_event(KIND_TSIG, 32'd3, '0, '0, '0, '0,
                              8'h04, 8'h02, 8'h18, 8'h08));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i])
      send_byte(stim_rows[i].b, stim_rows[i].tb, stim_rows[i].fixed, stim_rows[i].ev);

    byte_cnt = 0;
    while (byte_cnt < RANDOM_BYTES) gen_event();
    s_axis_tvalid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0)
      $display("midi_track_event_parser_core verification clean");
    else
      $display("midi_track_event_parser_core verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
src/mtep_pkg.sv
src/midi_track_event_parser_core.sv
sim/testbench.sv
